// ===== hdl/kect_pkg.sv =====
// package for the keyed event counter table
// holds table sizes, command and status codes, queue entry type and state types
// no dependencies
package kect_pkg;

  localparam int TABLE_SLOTS = 128;
  localparam int SLOT_W      = 7;
  localparam int USED_W      = 8;
  localparam int KEY_W       = 32;
  localparam int TOTAL_W     = 64;
  localparam int IVAL_W      = 32;
  localparam int ENTRY_W     = KEY_W + TOTAL_W + IVAL_W;
  localparam int Q_DEPTH     = 4;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 3;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 144;

  typedef enum logic [1:0] {
    CMD_COUNT = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_HIT      = 3'd0,
    ST_NEW      = 3'd1,
    ST_DROP     = 3'd2,
    ST_TICK     = 3'd3,
    ST_RD_OK    = 3'd4,
    ST_RD_EMPTY = 3'd5
  } status_t;

  typedef struct packed {
    status_t             status;
    logic [SLOT_W-1:0]   slot;
    logic [KEY_W-1:0]    key;
    logic [USED_W-1:0]   used;
  } q_entry_t;

  typedef enum logic [1:0] {
    F_EMPTY,
    F_MATCH,
    F_PUSH
  } front_state_t;

  typedef enum logic {
    B_IDLE,
    B_EXEC
  } back_state_t;

endpackage

// ===== hdl/kect_ram.sv =====
// generic single write port ram with one registered read port
// no dependencies
module kect_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/kect_fifo.sv =====
// short queue of classified commands between front and back
// depends on kect_pkg
module kect_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  kect_pkg::q_entry_t push_data,
  output logic               full,
  input  logic               pop,
  output kect_pkg::q_entry_t pop_data,
  output logic               empty
);
  import kect_pkg::*;

  q_entry_t             entries [Q_DEPTH];
  logic [Q_PTR_W-1:0]   wr_ptr;
  logic [Q_PTR_W-1:0]   rd_ptr;
  logic [Q_CNT_W-1:0]   count;

  assign full     = (count == Q_CNT_W'(Q_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// ===== hdl/kect_front.sv =====
// front part: accepts command beats, matches keys against the slot key lanes,
// allocates new slots and pushes classified commands; depends on kect_pkg
module kect_front (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [kect_pkg::IN_DATA_W-1:0]   s_tdata,
  input  logic [1:0]                       s_tuser,
  output logic                             q_push,
  output kect_pkg::q_entry_t               q_data,
  input  logic                             q_full
);
  import kect_pkg::*;

  front_state_t             state;
  front_state_t             state_next;
  cmd_t                     f_cmd;
  logic [KEY_W-1:0]         f_key;
  logic [SLOT_W-1:0]        f_rslot;
  logic [TABLE_SLOTS-1:0]   match_vec;
  logic [TABLE_SLOTS-1:0]   match_next;
  logic [KEY_W-1:0]         slot_keys [TABLE_SLOTS];
  logic [USED_W-1:0]        slots_used;
  logic [SLOT_W-1:0]        hit_slot;
  logic                     hit;
  logic                     accept;
  logic                     done;
  logic                     alloc;

  assign accept = s_tvalid && s_tready;
  assign done   = (f_cmd == CMD_NONE) || !q_full;

  for (genvar i = 0; i < TABLE_SLOTS; i++) begin : g_lane
    assign match_next[i] = (slot_keys[i] == f_key) && (USED_W'(i) < slots_used);
  end

  // keys are unique, so at most one lane matches
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (match_vec[i]) begin
        hit_slot = hit_slot | SLOT_W'(i);
      end
    end
    hit = |match_vec;
  end

  always_comb begin
    q_data.status = ST_TICK;
    q_data.slot   = '0;
    q_data.key    = '0;
    q_data.used   = slots_used;
    alloc         = 1'b0;
    case (f_cmd)
      CMD_COUNT: begin
        q_data.key = f_key;
        if (hit) begin
          q_data.status = ST_HIT;
          q_data.slot   = hit_slot;
        end else if (slots_used == USED_W'(TABLE_SLOTS)) begin
          q_data.status = ST_DROP;
        end else begin
          q_data.status = ST_NEW;
          q_data.slot   = slots_used[SLOT_W-1:0];
          q_data.used   = slots_used + 1'b1;
          alloc         = 1'b1;
        end
      end
      CMD_READ: begin
        q_data.slot = f_rslot;
        if ({1'b0, f_rslot} < slots_used) begin
          q_data.status = ST_RD_OK;
        end else begin
          q_data.status = ST_RD_EMPTY;
        end
      end
      default: begin
        q_data.status = ST_TICK;
      end
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    q_push   = 1'b0;
    unique case (state)
      F_EMPTY: s_tready = 1'b1;
      F_MATCH: s_tready = 1'b0;
      F_PUSH: begin
        s_tready = done;
        q_push   = (f_cmd != CMD_NONE) && !q_full;
      end
      default: s_tready = 1'b0;
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_EMPTY: if (accept) state_next = F_MATCH;
      F_MATCH: state_next = F_PUSH;
      F_PUSH: begin
        if (done) begin
          state_next = accept ? F_MATCH : F_EMPTY;
        end
      end
      default: state_next = F_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_EMPTY;
      slots_used <= '0;
    end else begin
      state <= state_next;
      if (q_push && alloc) begin
        slots_used <= slots_used + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_cmd   <= cmd_t'(s_tuser);
      f_key   <= s_tdata[KEY_W-1:0];
      f_rslot <= s_tdata[KEY_W+SLOT_W-1:KEY_W];
    end
    if (state == F_MATCH) begin
      match_vec <= match_next;
    end
    if (q_push && alloc) begin
      slot_keys[slots_used[SLOT_W-1:0]] <= f_key;
    end
  end

endmodule

// ===== hdl/kect_back.sv =====
// back part: pops classified commands, does the counter read-modify-write
// in the entry ram and holds the result beat; depends on kect_pkg, kect_ram
module kect_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  kect_pkg::q_entry_t              q_data,
  output logic                            q_pop,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [kect_pkg::OUT_DATA_W-1:0] m_tdata,
  output logic [2:0]                      m_tuser
);
  import kect_pkg::*;

  back_state_t             state;
  back_state_t             state_next;
  q_entry_t                b_entry;
  logic [TABLE_SLOTS-1:0]  ival_valid;
  logic [ENTRY_W-1:0]      rd_data;
  logic [ENTRY_W-1:0]      wr_data;
  logic [KEY_W-1:0]        rd_key;
  logic [TOTAL_W-1:0]      rd_total;
  logic [IVAL_W-1:0]       rd_ival;
  logic [IVAL_W-1:0]       iv_old;
  logic                    load;
  logic                    ram_we;
  status_t                 res_status;
  logic [SLOT_W-1:0]       res_slot;
  logic [KEY_W-1:0]        res_key;
  logic [TOTAL_W-1:0]      res_total;
  logic [IVAL_W-1:0]       res_ival;
  status_t                 out_status;
  logic [SLOT_W-1:0]       out_slot;
  logic [KEY_W-1:0]        out_key;
  logic [TOTAL_W-1:0]      out_total;
  logic [IVAL_W-1:0]       out_ival;
  logic [USED_W-1:0]       out_used;

  // entry layout: interval, total, key from the top bit down
  assign rd_key   = rd_data[KEY_W-1:0];
  assign rd_total = rd_data[KEY_W+TOTAL_W-1:KEY_W];
  assign rd_ival  = rd_data[ENTRY_W-1:KEY_W+TOTAL_W];
  assign wr_data  = {res_ival, res_total, res_key};

  kect_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (b_entry.slot),
    .wdata (wr_data),
    .re    (q_pop),
    .raddr (q_data.slot),
    .rdata (rd_data)
  );

  // interval counts cleared by a tick read as zero
  assign iv_old = ival_valid[b_entry.slot] ? rd_ival : '0;

  always_comb begin
    res_status = b_entry.status;
    res_slot   = '0;
    res_key    = '0;
    res_total  = '0;
    res_ival   = '0;
    case (b_entry.status)
      ST_HIT: begin
        res_slot  = b_entry.slot;
        res_key   = b_entry.key;
        res_total = rd_total + 1'b1;
        res_ival  = (iv_old == '1) ? iv_old : iv_old + 1'b1;
      end
      ST_NEW: begin
        res_slot  = b_entry.slot;
        res_key   = b_entry.key;
        res_total = TOTAL_W'(1);
        res_ival  = IVAL_W'(1);
      end
      ST_DROP: begin
        res_key = b_entry.key;
      end
      ST_RD_OK: begin
        res_slot  = b_entry.slot;
        res_key   = rd_key;
        res_total = rd_total;
        res_ival  = iv_old;
      end
      ST_RD_EMPTY: begin
        res_slot = b_entry.slot;
      end
      default: begin
        res_slot = '0;
      end
    endcase
  end

  always_comb begin
    q_pop  = 1'b0;
    load   = 1'b0;
    unique case (state)
      B_IDLE: q_pop = q_valid;
      B_EXEC: load  = !m_tvalid || m_tready;
      default: q_pop = 1'b0;
    endcase
    ram_we = load && ((b_entry.status == ST_HIT) || (b_entry.status == ST_NEW));
  end

  always_comb begin
    state_next = state;
    unique case (state)
      B_IDLE: if (q_valid) state_next = B_EXEC;
      B_EXEC: if (load) state_next = B_IDLE;
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= B_IDLE;
      m_tvalid   <= 1'b0;
      ival_valid <= '0;
    end else begin
      state <= state_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (load && (b_entry.status == ST_TICK)) begin
        ival_valid <= '0;
      end else if (ram_we) begin
        ival_valid[b_entry.slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      b_entry <= q_data;
    end
    if (load) begin
      out_status <= res_status;
      out_slot   <= res_slot;
      out_key    <= res_key;
      out_total  <= res_total;
      out_ival   <= res_ival;
      out_used   <= b_entry.used;
    end
  end

  assign m_tdata = {1'b0, out_used, out_ival, out_total, out_key, out_slot};
  assign m_tuser = out_status;

endmodule

// ===== hdl/keyed_event_counter_table_top.sv =====
// top level of the keyed event counter table
// depends on kect_pkg, kect_front, kect_fifo, kect_back
//
// Input channel s_*: one beat per command. tuser holds the command (count
// event, interval tick, read entry); tdata holds the reason key and the read
// slot. Output channel m_*: one beat per count, tick or read command; tuser
// holds the status, tdata the slot, key, total count, interval count and the
// number of used slots. Command code 3 is consumed and gives no beat.
// The front does the 128-lane key compare, then classifies and queues each
// command, and can take the next command while it queues one if the queue
// is not full; the back reads the entry ram, then updates and writes the
// counter, and pops the next command only once the result beat is loaded.
// A 4-entry queue parts front and back; when the receiver stalls, the held
// beat waits in the output register, the queue fills and then s_tready drops.
// Reset empties the table (used count zero) and clears all interval marks;
// entry contents are not cleared, so no clearing pass runs after reset.
module keyed_event_counter_table_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // reason_key [31:0], read_slot [38:32], zero [39]
  input  logic [kect_pkg::IN_DATA_W-1:0]  s_tdata,
  // cmd [1:0]
  input  logic [1:0]                      s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // slot [6:0], key_out [38:7], total_out [102:39], interval_out [134:103],
  // used_out [142:135], zero [143]
  output logic [kect_pkg::OUT_DATA_W-1:0] m_tdata,
  // status [2:0]
  output logic [2:0]                      m_tuser
);
  import kect_pkg::*;

  logic     q_push;
  logic     q_full;
  logic     q_pop;
  logic     q_empty;
  q_entry_t q_wdata;
  q_entry_t q_rdata;

  kect_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_push   (q_push),
    .q_data   (q_wdata),
    .q_full   (q_full)
  );

  kect_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .empty     (q_empty)
  );

  kect_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (!q_empty),
    .q_data   (q_rdata),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule

// ===== hdl/kect_check.sv =====
// port checker for the keyed event counter table, bound to the top level
// depends on kect_pkg and keyed_event_counter_table_top
module kect_check (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [kect_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic [2:0]                      m_tuser
);
  import kect_pkg::*;

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output beat changed while stalled");

  a_used_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[142:135] <= USED_W'(TABLE_SLOTS))
    else $error("used count above table size");

  a_new_counts: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_NEW) |->
      (m_tdata[102:39] == 64'd1) && (m_tdata[134:103] == 32'd1)
      && (m_tdata[6:0] == m_tdata[142:135] - 8'd1))
    else $error("new entry with wrong counts or slot");

  a_tick_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_TICK) |-> m_tdata[134:0] == '0)
    else $error("tick beat with nonzero fields");

  a_empty_after_rst: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("output beat right after reset");

endmodule

bind keyed_event_counter_table_top kect_check u_check (.*);
